/* hw/rtl/tds_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants for the triangular distribution sampler.
// No dependencies.
package tds_pkg;

   localparam int RANDOM_BITS_DEF = 16;
   localparam int QUEUE_DEPTH_DEF = 4;
   localparam int TIME_W          = 32;
   localparam int IN_W            = 16;
   localparam int CSR_AW          = 4;

   localparam logic [CSR_AW-1:0] ADDR_MIN  = 4'h0;
   localparam logic [CSR_AW-1:0] ADDR_MAX  = 4'h4;
   localparam logic [CSR_AW-1:0] ADDR_MODE = 4'h8;

   typedef struct packed {
      logic [TIME_W-1:0] min_time;
      logic [TIME_W-1:0] max_time;
      logic [TIME_W-1:0] mode_time;
   } tds_cfg_type;

   // Classified request: bounds and spans with the mode already clamped.
   typedef struct packed {
      logic [IN_W-1:0]   u;
      logic [TIME_W-1:0] a;
      logic [TIME_W-1:0] b;
      logic [TIME_W-1:0] span;
      logic [TIME_W-1:0] lspan;
      logic [TIME_W-1:0] rspan;
      logic              empty;
   } tds_item_type;

   typedef struct packed {
      logic       full;
      logic       empty;
      logic [7:0] count;
   } tds_qstat_type;

endpackage

/* hw/rtl/tds_if.sv */
`timescale 1ns / 1ps
// Valid/ready channel interfaces for request and response.
// Depends on nothing.
interface tds_req_if;
   logic        valid;
   logic        ready;
   logic [15:0] uniform_fraction;
   modport source (output valid, output uniform_fraction, input ready);
   modport sink (input valid, input uniform_fraction, output ready);
endinterface

interface tds_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] sample_time;
   modport source (output valid, output sample_time, input ready);
   modport sink (input valid, input sample_time, output ready);
endinterface

/* hw/rtl/tds_front.sv */
`timescale 1ns / 1ps
// Front end: accepts requests, clamps the mode and forms the spans.
// Depends on tds_pkg and tds_if.
module tds_front #(
   parameter int RANDOM_BITS = tds_pkg::RANDOM_BITS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  tds_pkg::tds_cfg_type cfg,
   tds_req_if.sink              req_chan,
   output tds_pkg::tds_item_type item,
   output logic                 item_valid,
   input  logic                 item_ready
);
   import tds_pkg::*;

   localparam logic [IN_W-1:0] U_MASK = (RANDOM_BITS >= IN_W) ? {IN_W{1'b1}} :
      IN_W'((33'd1 << RANDOM_BITS) - 33'd1);

   logic         fv_ff;
   tds_item_type item_ff, item_in;
   logic         take;
   logic [TIME_W-1:0] c;

   assign req_chan.ready = !fv_ff || item_ready;
   assign take = req_chan.valid && req_chan.ready;

   always_comb begin
      if (cfg.mode_time < cfg.min_time) c = cfg.min_time;
      else if (cfg.mode_time > cfg.max_time) c = cfg.max_time;
      else c = cfg.mode_time;
      item_in.u     = req_chan.uniform_fraction & U_MASK;
      item_in.a     = cfg.min_time;
      item_in.b     = cfg.max_time;
      item_in.span  = cfg.max_time - cfg.min_time;
      item_in.lspan = c - cfg.min_time;
      item_in.rspan = cfg.max_time - c;
      item_in.empty = cfg.max_time <= cfg.min_time;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fv_ff <= 1'b0;
      end else if (req_chan.ready) begin
         fv_ff <= req_chan.valid;
      end
      if (take) item_ff <= item_in;
   end

   assign item = item_ff;
   assign item_valid = fv_ff;
endmodule

/* hw/rtl/tds_queue.sv */
`timescale 1ns / 1ps
// Small request queue between front and back ends.
// Depends on tds_pkg.
module tds_queue #(
   parameter int QUEUE_DEPTH = tds_pkg::QUEUE_DEPTH_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  tds_pkg::tds_item_type push_item,
   input  logic                  push_valid,
   output logic                  push_ready,
   output tds_pkg::tds_item_type pop_item,
   output logic                  pop_valid,
   input  logic                  pop_ready,
   output tds_pkg::tds_qstat_type stat
);
   import tds_pkg::*;

   localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CW = $clog2(QUEUE_DEPTH + 1);

   tds_item_type     mem_ff [QUEUE_DEPTH];
   logic [PW-1:0]    wr_ff, rd_ff;
   logic [CW-1:0]    count_ff;
   logic             push, pop;

   assign push_ready = count_ff != CW'(QUEUE_DEPTH);
   assign pop_valid  = count_ff != '0;
   assign push = push_valid && push_ready;
   assign pop  = pop_valid && pop_ready;
   assign pop_item = mem_ff[rd_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff <= '0;
         rd_ff <= '0;
         count_ff <= '0;
      end else begin
         if (push) wr_ff <= (wr_ff == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ff + PW'(1);
         if (pop) rd_ff <= (rd_ff == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ff + PW'(1);
         if (push && !pop) count_ff <= count_ff + CW'(1);
         else if (pop && !push) count_ff <= count_ff - CW'(1);
      end
      if (push) mem_ff[wr_ff] <= push_item;
   end

   assign stat.full  = !push_ready;
   assign stat.empty = !pop_valid;
   assign stat.count = 8'(count_ff);
endmodule

/* hw/rtl/tds_back.sv */
`timescale 1ns / 1ps
// Back end: branch select, radicand multiply and pipelined square root.
// Depends on tds_pkg and tds_if.
module tds_back #(
   parameter int RANDOM_BITS = tds_pkg::RANDOM_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  tds_pkg::tds_item_type item,
   input  logic                  item_valid,
   output logic                  item_ready,
   tds_rsp_if.source             rsp_chan
);
   import tds_pkg::*;

   localparam int RB    = RANDOM_BITS;
   localparam int PW    = IN_W + TIME_W;
   localparam int XW    = TIME_W + RB;
   localparam int SW    = 2 * TIME_W + RB + 1;
   localparam int NST   = TIME_W;
   localparam int REM_W = TIME_W + 3;

   logic en;

   // stage 1: u * span
   logic              v1_ff;
   logic [PW-1:0]     p1_ff;
   tds_item_type      it1_ff;
   // stage 2: branch select
   logic              v2_ff, sub2_ff;
   logic [XW-1:0]     x2_ff;
   logic [TIME_W-1:0] m2_ff, base2_ff;
   // stage 3: partial products
   logic              v3_ff, sub3_ff;
   logic [2*TIME_W-1:0] pp0_ff;
   logic [TIME_W+RB-1:0] pp1_ff;
   logic [TIME_W-1:0] base3_ff;
   // root pipeline, index 0 is the radicand
   logic                vq_ff   [NST+1];
   logic                subq_ff [NST+1];
   logic [TIME_W-1:0]   baseq_ff[NST+1];
   logic [2*TIME_W-1:0] n_ff    [NST+1];
   logic [REM_W-1:0]    rem_ff  [NST+1];
   logic [TIME_W-1:0]   root_ff [NST+1];
   logic [2*TIME_W-1:0] n_in    [NST];
   logic [REM_W-1:0]    rem_in  [NST];
   logic [TIME_W-1:0]   root_in [NST];
   // output
   logic              out_vld_ff;
   logic [TIME_W-1:0] res_ff;

   logic [XW-1:0]     p_x, full_x, lsh_x;
   logic              branch;
   logic [SW-1:0]     sum;
   logic [REM_W-1:0]  sh_rem, trial;

   assign en = !out_vld_ff || rsp_chan.ready;
   assign item_ready = en;

   assign p_x    = XW'(p1_ff);
   assign full_x = XW'(it1_ff.span) << RB;
   assign lsh_x  = XW'(it1_ff.lspan) << RB;
   assign branch = p_x < lsh_x;
   assign sum    = SW'(pp0_ff) + (SW'(pp1_ff) << TIME_W);

   always_comb begin
      sh_rem = '0;
      trial  = '0;
      for (int k = 0; k < NST; k++) begin
         sh_rem = {rem_ff[k][REM_W-3:0], n_ff[k][2*TIME_W-1 -: 2]};
         trial  = {1'b0, root_ff[k], 2'b01};
         if (sh_rem >= trial) begin
            rem_in[k]  = sh_rem - trial;
            root_in[k] = {root_ff[k][TIME_W-2:0], 1'b1};
         end else begin
            rem_in[k]  = sh_rem;
            root_in[k] = {root_ff[k][TIME_W-2:0], 1'b0};
         end
         n_in[k] = n_ff[k] << 2;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         for (int k = 0; k <= NST; k++) vq_ff[k] <= 1'b0;
         out_vld_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= item_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         vq_ff[0] <= v3_ff;
         for (int k = 0; k < NST; k++) vq_ff[k+1] <= vq_ff[k];
         out_vld_ff <= vq_ff[NST];
      end
      if (en) begin
         p1_ff  <= PW'(item.u) * PW'(item.span);
         it1_ff <= item;
         // empty range: zero multiplier makes the root zero, result is min
         x2_ff    <= branch ? p_x : full_x - p_x;
         m2_ff    <= it1_ff.empty ? '0 : (branch ? it1_ff.lspan : it1_ff.rspan);
         base2_ff <= (branch || it1_ff.empty) ? it1_ff.a : it1_ff.b;
         sub2_ff  <= !branch && !it1_ff.empty;
         pp0_ff   <= (2*TIME_W)'(x2_ff[TIME_W-1:0]) * (2*TIME_W)'(m2_ff);
         pp1_ff   <= (TIME_W+RB)'(x2_ff[XW-1:TIME_W]) * (TIME_W+RB)'(m2_ff);
         base3_ff <= base2_ff;
         sub3_ff  <= sub2_ff;
         n_ff[0]     <= sum[RB +: 2*TIME_W];
         rem_ff[0]   <= '0;
         root_ff[0]  <= '0;
         baseq_ff[0] <= base3_ff;
         subq_ff[0]  <= sub3_ff;
         for (int k = 0; k < NST; k++) begin
            n_ff[k+1]     <= n_in[k];
            rem_ff[k+1]   <= rem_in[k];
            root_ff[k+1]  <= root_in[k];
            baseq_ff[k+1] <= baseq_ff[k];
            subq_ff[k+1]  <= subq_ff[k];
         end
         res_ff <= subq_ff[NST] ? baseq_ff[NST] - root_ff[NST]
                                : baseq_ff[NST] + root_ff[NST];
      end
   end

   assign rsp_chan.valid = out_vld_ff;
   assign rsp_chan.sample_time = res_ff;
endmodule

/* hw/rtl/triangular_distribution_sampler_top.sv */
`timescale 1ns / 1ps
// Triangular distribution sampler, top level.
// Throughput: one request per cycle while the response channel is ready.
// Request path: front register, queue, back end (product, branch select,
// partial products, radicand, 32-stage one-bit-per-stage square root, add).
// Reset (synchronous, active high) zeroes the bound registers and empties pipes.
module triangular_distribution_sampler_top #(
   parameter int RANDOM_BITS = tds_pkg::RANDOM_BITS_DEF,
   parameter int QUEUE_DEPTH = tds_pkg::QUEUE_DEPTH_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   tds_req_if.sink                    req_chan,
   tds_rsp_if.source                  rsp_chan,
   input  logic                       psel,
   input  logic                       penable,
   input  logic                       pwrite,
   input  logic [tds_pkg::CSR_AW-1:0] paddr,
   input  logic [31:0]                pwdata,
   output logic [31:0]                prdata,
   output logic                       pready
);
   import tds_pkg::*;

   tds_cfg_type   cfg_ff;
   tds_item_type  f_item, q_item;
   logic          f_valid, f_ready, q_valid, q_ready;
   tds_qstat_type qstat;
   logic          wr;

   assign pready = 1'b1;
   assign wr = psel && penable && pwrite && pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else if (wr) begin
         case (paddr)
            ADDR_MIN:  cfg_ff.min_time  <= pwdata;
            ADDR_MAX:  cfg_ff.max_time  <= pwdata;
            ADDR_MODE: cfg_ff.mode_time <= pwdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      case (paddr)
         ADDR_MIN:  prdata = cfg_ff.min_time;
         ADDR_MAX:  prdata = cfg_ff.max_time;
         ADDR_MODE: prdata = cfg_ff.mode_time;
         default:   prdata = '0;
      endcase
   end

   tds_front #(.RANDOM_BITS(RANDOM_BITS)) u_front (
      .clock(clock), .reset(reset), .cfg(cfg_ff), .req_chan(req_chan),
      .item(f_item), .item_valid(f_valid), .item_ready(f_ready)
   );

   tds_queue #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_queue (
      .clock(clock), .reset(reset),
      .push_item(f_item), .push_valid(f_valid), .push_ready(f_ready),
      .pop_item(q_item), .pop_valid(q_valid), .pop_ready(q_ready),
      .stat(qstat)
   );

   tds_back #(.RANDOM_BITS(RANDOM_BITS)) u_back (
      .clock(clock), .reset(reset), .item(q_item), .item_valid(q_valid),
      .item_ready(q_ready), .rsp_chan(rsp_chan)
   );

`ifndef SYNTHESIS
   a_q_bound: assert property (@(posedge clock) disable iff (reset)
      qstat.count <= 8'(QUEUE_DEPTH))
      else $error("queue count exceeds depth");
   a_q_flags: assert property (@(posedge clock) disable iff (reset)
      !(qstat.full && qstat.empty))
      else $error("queue full and empty at once");
   a_req_fwd: assert property (@(posedge clock) disable iff (reset)
      (req_chan.valid && req_chan.ready) |=> f_valid)
      else $error("accepted request not held in front stage");
`endif
endmodule

/* dv/tb.sv */
`timescale 1ns / 1ps
// Self-checking bench for the triangular distribution sampler: walks several
// bound/mode settings, checks every sample against a bit-exact predictor.
// Depends on tds_pkg, tds_if and triangular_distribution_sampler_top.
module tb;
   import tds_pkg::*;

   localparam int RBITS     = RANDOM_BITS_DEF;
   localparam int LATENCY   = 38;
   localparam int WDOG_MAX  = 20000;
   localparam int N_RANDOM  = 1000;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                psel = 1'b0;
   logic                penable = 1'b0;
   logic                pwrite = 1'b0;
   logic [CSR_AW-1:0]   paddr = '0;
   logic [31:0]         pwdata = '0;
   logic [31:0]         prdata;
   logic                pready;

   tds_req_if req_chan ();
   tds_rsp_if rsp_chan ();

   triangular_distribution_sampler_top uut (
      .clock(clock), .reset(reset), .req_chan(req_chan), .rsp_chan(rsp_chan),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // predictor copy of the bound registers
   logic [31:0] lo_bound, hi_bound, peak;

   logic [15:0] pending_fractions[$];
   logic [31:0] expected_samples[$];
   int          errors = 0;
   int          n_sent = 0;
   int          n_checked = 0;
   int          n_settings = 0;
   int          hold_off = 0;     // long receiver stall request
   int          idle_cycles = 0;

   function automatic logic [31:0] floor_sqrt(logic [63:0] n);
      logic [31:0] r;
      logic [63:0] c;
      r = '0;
      for (int i = 31; i >= 0; i--) begin
         c = {32'd0, r | (32'd1 << i)};
         if (c * c <= n)
            r = c[31:0];
      end
      return r;
   endfunction

   function automatic logic [31:0] triangular_sample(logic [15:0] frac);
      logic [63:0] u, one, span, lspan, rspan, c;
      logic [127:0] prod;
      u   = {48'd0, frac} & ((64'd1 << RBITS) - 1);
      one = 64'd1 << RBITS;
      if (hi_bound <= lo_bound)
         return lo_bound;
      c = peak;
      if (c < lo_bound) c = lo_bound;
      if (c > hi_bound) c = hi_bound;
      span  = hi_bound - lo_bound;
      lspan = c - lo_bound;
      rspan = hi_bound - c;
      if (u * span < (lspan << RBITS)) begin
         prod = ({64'd0, u * span} * lspan) >> RBITS;
         return lo_bound + floor_sqrt(prod[63:0]);
      end
      prod = ({64'd0, (one - u) * span} * rspan) >> RBITS;
      return hi_bound - floor_sqrt(prod[63:0]);
   endfunction

   function automatic void add_fraction(logic [15:0] f);
      pending_fractions = {pending_fractions, f};
   endfunction

   // driver: offer pending requests with random gaps
   int req_gap = 0;
   always @(posedge clock) begin
      if (reset) begin
         req_chan.valid <= 1'b0;
         req_chan.uniform_fraction <= '0;
      end else begin
         // predict every accepted request at its accepting edge
         if (req_chan.valid && req_chan.ready) begin
            expected_samples = {expected_samples,
                                triangular_sample(req_chan.uniform_fraction)};
            n_sent++;
         end
         if (req_chan.valid && !req_chan.ready) begin
            // hold
         end else if (req_gap > 0) begin
            req_gap <= req_gap - 1;
            req_chan.valid <= 1'b0;
         end else if (pending_fractions.size() > 0) begin
            req_chan.uniform_fraction <= pending_fractions.pop_front();
            req_chan.valid <= 1'b1;
            req_gap <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 9);
         end else begin
            req_chan.valid <= 1'b0;
         end
      end
   end

   // monitor: random ready, check each response against the oldest prediction
   int rsp_gap = 0;
   logic [31:0] want;
   always @(posedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (expected_samples.size() == 0) begin
               $display("%0t: unexpected response, actual %h", $time,
                        rsp_chan.sample_time);
               errors++;
            end else begin
               want = expected_samples.pop_front();
               if (rsp_chan.sample_time !== want) begin
                  $display("%0t: sample_time mismatch, expected %h actual %h",
                           $time, want, rsp_chan.sample_time);
                  errors++;
               end
               n_checked++;
            end
         end
         if (hold_off > 0) begin
            hold_off <= hold_off - 1;
            rsp_chan.ready <= 1'b0;
         end else if (rsp_gap > 0) begin
            rsp_gap <= rsp_gap - 1;
            rsp_chan.ready <= 1'b0;
         end else begin
            rsp_chan.ready <= 1'b1;
            if (rsp_chan.valid && rsp_chan.ready)
               rsp_gap <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 9);
         end
      end
   end

   // watchdog on cycles with no accepted request or response
   always @(posedge clock) begin
      if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WDOG_MAX) begin
         $display("watchdog expired");
         $display("TB_ERROR");
         $finish;
      end
   end

   task automatic csr_write(input logic [CSR_AW-1:0] addr, input logic [31:0] data);
      psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
      paddr <= addr; pwdata <= data;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
      case (addr)
         ADDR_MIN:  lo_bound = data;
         ADDR_MAX:  hi_bound = data;
         ADDR_MODE: peak = data;
         default: ;
      endcase
   endtask

   task automatic drain();
      while (pending_fractions.size() > 0 || req_chan.valid || expected_samples.size() > 0)
         @(posedge clock);
      repeat (LATENCY + 4) @(posedge clock);
   endtask

   task automatic apply_setting(logic [31:0] a, logic [31:0] b, logic [31:0] c);
      drain();
      csr_write(ADDR_MIN, a);
      csr_write(ADDR_MAX, b);
      csr_write(ADDR_MODE, c);
      n_settings++;
   endtask

   task automatic queue_fractions(int n);
      for (int i = 0; i < n; i++) begin
         case ($urandom_range(0, 7))
            0: add_fraction(16'h0000);
            1: add_fraction(16'hFFFF);
            default: add_fraction(16'($urandom));
         endcase
      end
   endtask

   task automatic random_bounds();
      logic [31:0] a, b, c;
      case ($urandom_range(0, 5))
         0: begin a = $urandom; b = $urandom; c = $urandom; end
         1: begin a = 0; b = 32'hFFFF_FFFF; c = $urandom; end
         2: begin a = $urandom_range(0, 1000); b = a + $urandom_range(1, 50);
                  c = a + $urandom_range(0, 60); end
         3: begin a = $urandom; b = a; c = $urandom; end
         default: begin
            a = $urandom >> $urandom_range(0, 31);
            b = a + ($urandom >> $urandom_range(0, 31));
            if (b < a) b = 32'hFFFF_FFFF;
            c = a + ($urandom_range(0, 1) ? 0 : (b - a) / ($urandom_range(1, 4)));
         end
      endcase
      apply_setting(a, b, c);
   endtask

   initial begin
      lo_bound = '0; hi_bound = '0; peak = '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: reset values give an empty range
      add_fraction(16'h0000);
      add_fraction(16'hFFFF);
      // full range, mode in the middle
      apply_setting(32'h0000_0000, 32'hFFFF_FFFF, 32'h8000_0000);
      add_fraction(16'h0000);
      add_fraction(16'h7FFF);
      add_fraction(16'h8000);
      add_fraction(16'hFFFF);
      add_fraction(16'hAAAA);
      add_fraction(16'h5555);
      // mode at lower bound, at upper bound, below and above bounds
      apply_setting(32'h0001_0000, 32'h0005_0000, 32'h0001_0000);
      add_fraction(16'h0000);
      add_fraction(16'hFFFF);
      add_fraction(16'h1234);
      apply_setting(32'h0001_0000, 32'h0005_0000, 32'h0005_0000);
      add_fraction(16'h0000);
      add_fraction(16'hFFFF);
      add_fraction(16'hC000);
      apply_setting(32'h0010_0000, 32'hFFFF_FFFF, 32'h0000_0001);
      add_fraction(16'h4000);
      add_fraction(16'hFFFF);
      apply_setting(32'h0000_0000, 32'h0010_0000, 32'hFFFF_FFFF);
      add_fraction(16'h0001);
      add_fraction(16'hFFFE);
      // max below min, then a one-wide range with the mode at min
      apply_setting(32'hFFFF_FFFF, 32'h0000_0000, 32'h1234_5678);
      add_fraction(16'h9999);
      apply_setting(32'h0000_0001, 32'h0000_0002, 32'h0000_0001);
      add_fraction(16'h0000);
      add_fraction(16'hFFFF);

      // random settings; long receiver stall once to back up the pipe
      for (int s = 0; s < 20; s++) begin
         random_bounds();
         if (s == 3)
            hold_off = 300;
         queue_fractions(N_RANDOM / 20);
         if (s == 10) begin
            // pause the sender until all results are back
            while (pending_fractions.size() > 0 || req_chan.valid
                   || expected_samples.size() > 0)
               @(posedge clock);
         end
      end
      drain();

      $display("covered %0d requests, %0d responses checked over %0d settings",
               n_sent, n_checked, n_settings);
      if (errors == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end
endmodule

/* triangular_distribution_sampler_top.f */
hw/rtl/tds_pkg.sv
hw/rtl/tds_if.sv
hw/rtl/tds_front.sv
hw/rtl/tds_queue.sv
hw/rtl/tds_back.sv
hw/rtl/triangular_distribution_sampler_top.sv
dv/tb.sv
